@@ rtl/core/fdat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feasible direction arc tracker package
// Shared constants, the CORDIC arctangent table, the queue item type and the
// front-end state type.
// ----------------------------------------------------------------------------
package fdat_pkg;

   // Angle accumulator fraction bits, coordinate bits and CORDIC iterations.
   localparam int ANGLE_BITS    = 16;
   localparam int COORD_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   // The vector is scaled so that no micro-rotation ever drops a bit.
   localparam int FRAC_BITS = 59 - COORD_BITS;
   // Difference (COORD_BITS + 1), CORDIC gain (2 bits) and fraction bits.
   localparam int CORDIC_W  = COORD_BITS + 3 + FRAC_BITS;
   localparam int STAGE_W   = $clog2(CORDIC_STAGES);

   // Angles at the block boundary: 65536 per full turn.
   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam logic [16:0] HALF_TURN    = 17'h08000;

   // atan(2^-i) in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURN32 [32] = '{
      32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41721,     32'd20860,
      32'd10430,     32'd5215,      32'd2607,      32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81,
      32'd40,        32'd20,        32'd10,        32'd5,
      32'd2,         32'd1,         32'd0,         32'd0
   };

   // Per-iteration angle step, truncated to the accumulator width.
   function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
      logic [31:0] full;
      full = ATAN_TURN32[idx] >> (32 - ANGLE_BITS);
      return full[ANGLE_BITS-1:0];
   endfunction

   // Truncate or zero-extend an accumulator angle to 16 bits.
   function automatic logic [15:0] angle_to_16(input logic [ANGLE_BITS-1:0] z);
      logic [31:0] wide;
      wide = 32'(z) << (32 - ANGLE_BITS);
      return wide[31:16];
   endfunction

   // One classified segment handed from the front end to the arc unit.
   typedef struct packed {
      logic        restart;
      logic [15:0] angle;
   } fdat_item_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_ROTATE,
      FS_PUSH
   } front_state_type;

endpackage

@@ rtl/core/fdat_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment request channel
// Valid/ready channel that carries one segment and its restart flag.
// ----------------------------------------------------------------------------
interface fdat_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [15:0] start_x;
   logic [15:0] start_y;
   logic [15:0] end_x;
   logic [15:0] end_y;

   modport source (output valid, restart, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink   (input valid, restart, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

@@ rtl/core/fdat_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc response channel
// Valid/ready channel that carries the feasible arc after each segment.
// ----------------------------------------------------------------------------
interface fdat_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] arc_from;
   logic [15:0] arc_to;
   logic        feasible;

   modport source (output valid, arc_from, arc_to, feasible, input ready);
   modport sink   (input valid, arc_from, arc_to, feasible, output ready);
endinterface

@@ rtl/core/fdat_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction front end
// Accepts a segment, forms its difference vector and finds its direction
// angle with an iterative vectoring CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module fdat_front (
   input  logic                   clock,
   input  logic                   reset,
   fdat_req_if.sink               req_bus,
   output logic                   push_valid,
   input  logic                   push_ready,
   output fdat_pkg::fdat_item_type push_item
);
   import fdat_pkg::*;

   front_state_type              state_ff, state_in;
   logic [STAGE_W-1:0]           stage_ff, stage_in;
   logic signed [CORDIC_W-1:0]   x_ff, x_in;
   logic signed [CORDIC_W-1:0]   y_ff, y_in;
   logic [ANGLE_BITS-1:0]        z_ff, z_in;
   logic                         restart_ff, restart_in;
   logic                         zero_ff, zero_in;

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic signed [CORDIC_W-1:0]   x_load;
   logic signed [CORDIC_W-1:0]   y_load;
   logic signed [CORDIC_W-1:0]   x_shift;
   logic signed [CORDIC_W-1:0]   y_shift;
   logic [ANGLE_BITS-1:0]        step;

   // Difference vector, sign-extended and scaled into the CORDIC format.
   assign dx = $signed({req_bus.end_x[COORD_BITS-1], req_bus.end_x[COORD_BITS-1:0]})
             - $signed({req_bus.start_x[COORD_BITS-1], req_bus.start_x[COORD_BITS-1:0]});
   assign dy = $signed({req_bus.end_y[COORD_BITS-1], req_bus.end_y[COORD_BITS-1:0]})
             - $signed({req_bus.start_y[COORD_BITS-1], req_bus.start_y[COORD_BITS-1:0]});
   assign x_load = {{(CORDIC_W-COORD_BITS-1-FRAC_BITS){dx[COORD_BITS]}}, dx,
                    {FRAC_BITS{1'b0}}};
   assign y_load = {{(CORDIC_W-COORD_BITS-1-FRAC_BITS){dy[COORD_BITS]}}, dy,
                    {FRAC_BITS{1'b0}}};

   // Shared micro-rotation datapath.
   assign x_shift = x_ff >>> stage_ff;
   assign y_shift = y_ff >>> stage_ff;
   assign step    = atan_step(5'(stage_ff));

   assign push_item.restart = restart_ff;
   assign push_item.angle   = zero_ff ? 16'h0000 : angle_to_16(z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      stage_ff   <= stage_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      restart_ff <= restart_in;
      zero_ff    <= zero_in;
   end

   // Sequencer: load, rotate CORDIC_STAGES times, then hand off to the queue.
   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      restart_in    = restart_ff;
      zero_in       = zero_ff;
      req_bus.ready = 1'b0;
      push_valid    = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               restart_in = req_bus.restart;
               zero_in    = (dx == '0) && (dy == '0);
               stage_in   = '0;
               // A vector in the left half plane is first turned by a half turn.
               if (dx[COORD_BITS]) begin
                  x_in = -x_load;
                  y_in = -y_load;
                  z_in = {1'b1, {(ANGLE_BITS-1){1'b0}}};
               end else begin
                  x_in = x_load;
                  y_in = y_load;
                  z_in = '0;
               end
               state_in = FS_ROTATE;
            end
         end
         FS_ROTATE: begin
            if (!y_ff[CORDIC_W-1]) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + step;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - step;
            end
            stage_in = stage_ff + 1'b1;
            if (stage_ff == STAGE_W'(CORDIC_STAGES - 1)) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/fdat_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction queue
// Two-entry queue that decouples the CORDIC front end from the arc unit.
// ----------------------------------------------------------------------------
module fdat_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  fdat_pkg::fdat_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output fdat_pkg::fdat_item_type pop_item
);
   import fdat_pkg::*;

   fdat_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push_fire;
   logic          pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_fire;
      rd_ptr_in = rd_ptr_ff ^ pop_fire;
      count_in  = count_ff + {1'b0, push_fire} - {1'b0, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/fdat_arc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc intersection unit
// Intersects each segment's half-turn arc with the stored feasible arc and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module fdat_arc (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  fdat_pkg::fdat_item_type pop_item,
   fdat_rsp_if.source              rsp_bus
);
   import fdat_pkg::*;

   logic        have_arc_ff, have_arc_in;
   logic        arc_empty_ff, arc_empty_in;
   logic [15:0] arc_start_ff, arc_start_in;
   logic [16:0] arc_len_ff, arc_len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] begin_ff, begin_in;
   logic [15:0] end_ff, end_in;
   logic        feasible_ff, feasible_in;

   logic        pop_fire;
   logic [15:0] cand_start;
   logic [15:0] offset;
   logic [15:0] back_off;
   logic [16:0] rest_stored;
   logic [16:0] rest_new;
   logic [15:0] sum_end;

   // The output register may be refilled in the cycle its result is taken.
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign pop_fire  = pop_valid && pop_ready;

   assign cand_start  = pop_item.angle - QUARTER_TURN;
   assign offset      = cand_start - arc_start_ff;
   assign back_off    = arc_start_ff - cand_start;
   assign rest_stored = arc_len_ff - {1'b0, offset};
   assign rest_new    = HALF_TURN - {1'b0, back_off};

   // Arc update and result formation.
   always_comb begin
      have_arc_in  = have_arc_ff;
      arc_empty_in = arc_empty_ff;
      arc_start_in = arc_start_ff;
      arc_len_in   = arc_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (pop_fire) begin
         priority if (pop_item.restart || !have_arc_ff) begin
            arc_start_in = cand_start;
            arc_len_in   = HALF_TURN;
            have_arc_in  = 1'b1;
            arc_empty_in = 1'b0;
         end else if (arc_empty_ff) begin
            // Infeasibility sticks until the next restart.
            arc_empty_in = 1'b1;
         end else if ({1'b0, offset} <= arc_len_ff) begin
            // The new arc begins inside the stored one.
            arc_start_in = cand_start;
            arc_len_in   = (HALF_TURN < rest_stored) ? HALF_TURN : rest_stored;
         end else if ({1'b0, back_off} <= HALF_TURN) begin
            // The stored arc begins inside the new one.
            arc_len_in   = (arc_len_ff < rest_new) ? arc_len_ff : rest_new;
         end else begin
            arc_empty_in = 1'b1;
         end
         rsp_valid_in = 1'b1;
      end
      sum_end = arc_start_in + arc_len_in[15:0];
      if (arc_empty_in) begin
         begin_in    = 16'h0000;
         end_in      = 16'h0000;
         feasible_in = 1'b0;
      end else begin
         begin_in    = arc_start_in;
         end_in      = sum_end;
         feasible_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_arc_ff  <= 1'b0;
         arc_empty_ff <= 1'b0;
         arc_start_ff <= 16'h0000;
         arc_len_ff   <= 17'h00000;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_arc_ff  <= have_arc_in;
         arc_empty_ff <= arc_empty_in;
         arc_start_ff <= arc_start_in;
         arc_len_ff   <= arc_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop_fire) begin
         begin_ff    <= begin_in;
         end_ff      <= end_in;
         feasible_ff <= feasible_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.arc_from = begin_ff;
   assign rsp_bus.arc_to   = end_ff;
   assign rsp_bus.feasible = feasible_ff;

endmodule

@@ rtl/core/feasible_direction_arc_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feasible direction arc tracker
// Finds each segment's direction and keeps the arc of directions that have a
// positive component along every segment since the last restart.
// ----------------------------------------------------------------------------
// In the front end each segment is accepted and its vector loaded, then put
// through CORDIC_STAGES (16) micro-rotations in a single shared
// shift-and-add stage, and its angle is handed to a two-entry queue, a step that
// waits while the queue is full. The front end accepts the next segment in the
// cycle after that hand-off, so it works on one segment at a time. The arc unit
// registers the result for each queued angle, and a result can wait in the
// output register while the front end already works on later segments.
// Angles are 65536 per turn; an empty intersection reports zeros with
// feasible low until a segment with restart set arrives.
module feasible_direction_arc_tracker (
   input  logic      clock,
   input  logic      reset,
   fdat_req_if.sink  req_bus,
   fdat_rsp_if.source rsp_bus
);
   import fdat_pkg::*;

   logic          push_valid;
   logic          push_ready;
   fdat_item_type push_item;
   logic          pop_valid;
   logic          pop_ready;
   fdat_item_type pop_item;

   // CORDIC front end.
   fdat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Decoupling queue.
   fdat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Arc intersection back end.
   fdat_arc u_arc (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_bus   (rsp_bus)
   );

`ifndef ASSERT_OFF
   // The front end works on one segment at a time.
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("front end accepted a segment while busy");

   // An angle pushed into an empty queue is visible to the arc unit next cycle.
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && !pop_valid) |=> pop_valid)
      else $error("queued angle lost");

   // An infeasible result carries an all-zero arc.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.feasible) |->
      (rsp_bus.arc_from == 16'h0000 && rsp_bus.arc_to == 16'h0000))
      else $error("infeasible result with nonzero arc");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feasible direction arc tracker testbench
// Drives segments into the tracker with bursty, stalled handshakes and checks
// every reported arc against a typed row's arc, else against a CORDIC and
// arc-intersection predictor kept in step with the accepted transfers. A short
// directed list comes first, then scattered chains mixed with random noise.
// ----------------------------------------------------------------------------
module tb;
   import fdat_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   // One reported arc.
   typedef struct packed {
      logic [15:0] arc_from;
      logic [15:0] arc_to;
      logic        feasible;
   } arc_result_type;

   // One directed segment; typed rows carry their own expected arc.
   typedef struct packed {
      logic           restart;
      logic [15:0]    sx;
      logic [15:0]    sy;
      logic [15:0]    ex;
      logic [15:0]    ey;
      logic           typed;
      arc_result_type want;
   } segment_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_mode_type;

   localparam arc_result_type ARC_ZERO_DIR = '{16'hC000, 16'h4000, 1'b1};
   localparam arc_result_type ARC_LOST     = '{16'h0000, 16'h0000, 1'b0};

   localparam int NUM_ROWS = 21;
   localparam segment_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // First segment after reset starts an arc; zero length gives angle 0.
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, ARC_ZERO_DIR},
      '{1'b0, 16'd1234, 16'hFFB3, 16'd1234, 16'hFFB3, 1'b1, ARC_ZERO_DIR},
      // Opposite directions: the arcs touch only at their ends.
      '{1'b1, 16'd0, 16'd0, 16'd3, 16'd5, 1'b0, '0},
      '{1'b0, 16'd10, 16'd10, 16'd7, 16'd5, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd1, 16'd0, 1'b0, '0},
      // Largest coordinate differences.
      '{1'b1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, '0},
      // Three directions that leave nothing feasible, which then sticks.
      '{1'b1, 16'd0, 16'd0, 16'h7FFF, 16'd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'h8000, 16'h8000, 1'b1, ARC_LOST},
      '{1'b0, 16'd0, 16'd0, 16'd1, 16'd0, 1'b1, ARC_LOST},
      '{1'b0, 16'd5, 16'd5, 16'd5, 16'd5, 1'b1, ARC_LOST},
      '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, ARC_ZERO_DIR},
      '{1'b0, 16'd100, 16'hFF9C, 16'hFF38, 16'd300, 1'b0, '0},
      // Negative x with zero y, then straight down.
      '{1'b1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, '0},
      // New arc starting before the stored one.
      '{1'b1, 16'd0, 16'd0, 16'd1, 16'd1, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd1, 16'hFFFF, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 1'b0, '0},
      '{1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, '0},
      '{1'b0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   fdat_req_if req_bus ();
   fdat_rsp_if rsp_bus ();

   feasible_direction_arc_tracker DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: the stored arc as start plus counterclockwise span.
   logic [15:0] arc_origin = '0;
   logic [16:0] arc_span   = '0;
   logic        arc_live   = 1'b0;
   logic        arc_lost   = 1'b0;

   arc_result_type pending_arcs [$];
   arc_result_type observed_want;
   int             fail_count     = 0;
   int             accepted_count = 0;
   int             burst_left     = 0;
   int             cycle_count    = 0;
   stall_mode_type stall_mode     = STALL_NONE;
   int             mode_left      = 0;

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Direction of a segment by vectoring CORDIC, 65536 per turn.
   function automatic logic [15:0] segment_heading(input logic [15:0] sx, input logic [15:0] sy,
                                                   input logic [15:0] ex, input logic [15:0] ey);
      longint      dx, dy, x, y, xs, ys;
      logic [63:0] z, step;
      dx = longint'($signed(ex)) - longint'($signed(sx));
      dy = longint'($signed(ey)) - longint'($signed(sy));
      if (dx == 0 && dy == 0) return 16'd0;
      x = dx * (longint'(1) << (59 - COORD_BITS));
      y = dy * (longint'(1) << (59 - COORD_BITS));
      z = '0;
      // Left half plane: turn by a half turn first.
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'd1 << (ANGLE_BITS - 1);
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         step = 64'(ATAN_TURN32[i] >> (32 - ANGLE_BITS));
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + step;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - step;
         end
      end
      z = z & ((64'd1 << ANGLE_BITS) - 64'd1);
      if (ANGLE_BITS >= 16) return 16'(z >> (ANGLE_BITS - 16));
      return 16'(z << (16 - ANGLE_BITS));
   endfunction

   // Intersect the half turn around a heading with the stored arc.
   function automatic arc_result_type advance_arc(input logic restart,
                                                  input logic [15:0] heading);
      logic [15:0]    new_origin, off, back;
      logic [16:0]    rest;
      arc_result_type r;
      new_origin = heading - QUARTER_TURN;
      if (restart || !arc_live) begin
         arc_origin = new_origin;
         arc_span   = HALF_TURN;
         arc_live   = 1'b1;
         arc_lost   = 1'b0;
      end else if (!arc_lost) begin
         off  = new_origin - arc_origin;
         back = arc_origin - new_origin;
         if ({1'b0, off} <= arc_span) begin
            // New arc begins inside the stored one.
            rest       = arc_span - {1'b0, off};
            arc_origin = new_origin;
            arc_span   = (HALF_TURN < rest) ? HALF_TURN : rest;
         end else if ({1'b0, back} <= HALF_TURN) begin
            // Stored arc begins inside the new one.
            rest     = HALF_TURN - {1'b0, back};
            arc_span = (arc_span < rest) ? arc_span : rest;
         end else begin
            arc_lost = 1'b1;
         end
      end
      if (arc_lost) begin
         r = '0;
      end else begin
         r.arc_from = arc_origin;
         r.arc_to   = arc_origin + arc_span[15:0];
         r.feasible = 1'b1;
      end
      return r;
   endfunction

   // Offer one segment in a bursty stream; entered and left at a falling edge.
   task automatic send_segment(input logic restart, input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] ex, input logic [15:0] ey,
                               input logic typed, input arc_result_type want);
      arc_result_type predicted;
      int             gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x   <= ex;
      req_bus.end_y   <= ey;
      do @(posedge clock); while (!req_bus.ready);
      predicted = advance_arc(restart, segment_heading(sx, sy, ex, ey));
      pending_arcs.push_back(typed ? want : predicted);
      accepted_count++;
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding arc has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_arcs.size() != 0);
   endtask

   // Extremes are favored so that sign and overflow corners show up often.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Segments scattered around one base direction, usually led by a restart.
   task automatic run_chain();
      int base_dx, base_dy, spread, dx, dy, sx, sy, count;
      logic restart;
      base_dx = int'($urandom_range(0, 6000)) - 3000;
      base_dy = int'($urandom_range(0, 6000)) - 3000;
      case ($urandom_range(0, 3))
         0: spread = 2;
         1: spread = 50;
         2: spread = 800;
         default: spread = 3000;
      endcase
      count   = $urandom_range(2, 14);
      restart = ($urandom_range(0, 4) != 0);
      dx = base_dx;
      dy = base_dy;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 11))
            0: begin
               dx = 0;
               dy = 0;
            end
            1: begin
               // Exact reverse of the previous direction.
               dx = -dx;
               dy = -dy;
            end
            default: begin
               dx = base_dx + int'($urandom_range(0, 2 * spread)) - spread;
               dy = base_dy + int'($urandom_range(0, 2 * spread)) - spread;
            end
         endcase
         sx = int'($urandom_range(0, 24000)) - 12000;
         sy = int'($urandom_range(0, 24000)) - 12000;
         send_segment(k == 0 ? restart : 1'b0, 16'(sx), 16'(sy), 16'(sx + dx), 16'(sy + dy),
                      1'b0, '0);
      end
   endtask

   // Receiver ready follows a randomly chosen stall pattern, redrawn when its random run length expires.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(32, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_bus.ready <= 1'b1;
         STALL_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         default:        rsp_bus.ready <= (cycle_count[2:0] != 3'd0);
      endcase
   end

   // Compare each arc transfer with the oldest expected arc.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_arcs.size() == 0) begin
            $display("%0t: unexpected arc begin=%h end=%h feasible=%b", $time,
                     rsp_bus.arc_from, rsp_bus.arc_to, rsp_bus.feasible);
            fail_count++;
         end else begin
            observed_want = pending_arcs.pop_front();
            if (rsp_bus.arc_from !== observed_want.arc_from) begin
               $display("%0t: arc_from expected %h actual %h", $time,
                        observed_want.arc_from, rsp_bus.arc_from);
               fail_count++;
            end
            if (rsp_bus.arc_to !== observed_want.arc_to) begin
               $display("%0t: arc_to expected %h actual %h", $time,
                        observed_want.arc_to, rsp_bus.arc_to);
               fail_count++;
            end
            if (rsp_bus.feasible !== observed_want.feasible) begin
               $display("%0t: feasible expected %b actual %b", $time,
                        observed_want.feasible, rsp_bus.feasible);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, random chains and noise, drain.
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x   = '0;
      req_bus.end_y   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         send_segment(DIRECTED_ROWS[r].restart, DIRECTED_ROWS[r].sx, DIRECTED_ROWS[r].sy,
                      DIRECTED_ROWS[r].ex, DIRECTED_ROWS[r].ey,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
      drain_results();

      while (accepted_count < NUM_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            send_segment(1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                         pick_coord(), pick_coord(), 1'b0, '0);
         end else begin
            run_chain();
         end
         if (accepted_count >= NUM_ROWS + RANDOM_ITEMS / 2 && burst_left >= 0
             && accepted_count < NUM_ROWS + RANDOM_ITEMS / 2 + 15) begin
            drain_results();
            burst_left = 0;
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_arcs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
